/* design/ppu_pkg.sv */
// Package for the packed pixel unpacker.
// Shared types, register and command codes, and the RGB555 channel widening.
// No dependencies.
`timescale 1ns / 1ps

package ppu_pkg;

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD   = 2'd2;

  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_PAL  = 1'b1;

  localparam logic [2:0] DEPTH_1  = 3'd0;
  localparam logic [2:0] DEPTH_2  = 3'd1;
  localparam logic [2:0] DEPTH_4  = 3'd2;
  localparam logic [2:0] DEPTH_8  = 3'd3;
  localparam logic [2:0] DEPTH_16 = 3'd4;
  localparam logic [2:0] DEPTH_24 = 3'd5;
  localparam logic [2:0] DEPTH_32 = 3'd6;

  localparam logic [3:0] BYTE_BITS = 4'd8;
  localparam logic [7:0] OPAQUE    = 8'hff;

  typedef struct packed {
    logic [7:0]  pixel_index;
    logic [31:0] color;      // {a, b, g, r}
    logic        use_pal;
    logic        row_end;
    logic        run_last;
  } pix_t;

  typedef struct packed {
    logic        we;
    logic [7:0]  waddr;
    logic [31:0] wdata;
    logic        re;
    logic [7:0]  raddr;
  } pal_req_t;

  function automatic logic [7:0] widen5(input logic [4:0] c);
    return {c, c[4:2]};
  endfunction

endpackage

/* design/ppu_palette.sv */
// Palette memory: 256 x 32 RGBA entries, one write and one registered read port.
// Depends on ppu_pkg.
`timescale 1ns / 1ps

module ppu_palette (
  input  logic              clk,
  input  ppu_pkg::pal_req_t req,
  output logic [31:0]       rdata
);
  import ppu_pkg::*;

  logic [31:0] pal_mem [256];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      pal_mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= pal_mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/ppu_unpack.sv */
// Input word register and unpacking state: one pixel per cycle from it unless stalled.
// Depends on ppu_pkg.
`timescale 1ns / 1ps

module ppu_unpack #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_cmd,
  input  logic [7:0]        in_data_byte,
  input  logic [7:0]        in_pal_index,
  input  logic [31:0]       in_pal_color,
  input  logic [2:0]        depth_mode,
  input  logic [12:0]       row_width,
  input  logic [7:0]        pad_bytes,
  input  logic              out_ready,
  output logic              pix_valid,
  output ppu_pkg::pix_t     pix,
  output ppu_pkg::pal_req_t pal_req,
  output logic              busy
);
  import ppu_pkg::*;

  localparam int RPW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW  = ($clog2(MAX_WIDTH + 1) > 13) ? $clog2(MAX_WIDTH + 1) : 13;

  logic           hold_valid_r, hold_valid_nxt;
  logic           cmd_r;
  logic [7:0]     byte_r;
  logic [7:0]     pidx_r;
  logic [31:0]    pcolor_r;
  logic [3:0]     bit_pos_r, bit_pos_nxt;
  logic [RPW-1:0] row_pos_r, row_pos_nxt;
  logic [1:0]     bip_r, bip_nxt;
  logic [23:0]    partial_r, partial_nxt;
  logic [7:0]     skip_r, skip_nxt;

  logic           has_pix, done, step, accept, last;
  logic [CW-1:0]  rw_ext, eff_w, rp_inc;
  logic [3:0]     bpp, bp_next;
  logic [7:0]     mask, idx;
  logic [2:0]     need;
  logic [31:0]    full;
  logic [15:0]    w16;
  pix_t           pix_c;

  always_comb begin
    rw_ext = CW'(row_width);
    if (rw_ext == '0) begin
      eff_w = CW'(1);
    end else if (rw_ext > CW'(MAX_WIDTH)) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = rw_ext;
    end
    rp_inc = CW'(row_pos_r) + CW'(1);
    last   = rp_inc >= eff_w;
  end

  always_comb begin
    bpp     = 4'(4'd1 << depth_mode[1:0]);
    mask    = 8'((9'd1 << bpp) - 9'd1);
    bp_next = bit_pos_r - bpp;
    idx     = (byte_r >> bp_next) & mask;
    need    = depth_mode - 3'd2;
    full    = {8'd0, partial_r} | (32'(byte_r) << {bip_r, 3'b000});
    w16     = full[15:0];
  end

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    bit_pos_nxt    = bit_pos_r;
    row_pos_nxt    = row_pos_r;
    bip_nxt        = bip_r;
    partial_nxt    = partial_r;
    skip_nxt       = skip_r;
    has_pix        = 1'b0;
    done           = 1'b0;
    pix_c          = '0;

    if (hold_valid_r) begin
      if (cmd_r == CMD_PAL) begin
        done = 1'b1;
      end else if (skip_r != 8'd0) begin
        done     = 1'b1;
        skip_nxt = skip_r - 8'd1;
      end else if (depth_mode <= DEPTH_8) begin
        has_pix           = 1'b1;
        done              = last || (bp_next < bpp);
        bit_pos_nxt       = done ? BYTE_BITS : bp_next;
        pix_c.pixel_index = idx;
        pix_c.use_pal     = 1'b1;
      end else if (depth_mode <= DEPTH_32) begin
        done = 1'b1;
        if (({1'b0, bip_r} + 3'd1) < need) begin
          partial_nxt = full[23:0];
          bip_nxt     = bip_r + 2'd1;
        end else begin
          has_pix     = 1'b1;
          partial_nxt = '0;
          bip_nxt     = '0;
          unique case (depth_mode)
            DEPTH_16: pix_c.color = {OPAQUE, widen5(w16[4:0]), widen5(w16[9:5]),
                                     widen5(w16[14:10])};
            DEPTH_24: pix_c.color = {OPAQUE, full[23:0]};
            default:  pix_c.color = full;
          endcase
        end
      end else begin
        done = 1'b1;
      end

      if (has_pix) begin
        pix_c.row_end  = last;
        pix_c.run_last = done;
        row_pos_nxt    = last ? '0 : rp_inc[RPW-1:0];
        if (last) begin
          skip_nxt = pad_bytes;
        end
      end
    end

    step   = hold_valid_r && (!has_pix || out_ready);
    accept = in_valid && !in_stall;
    if (step && done) begin
      hold_valid_nxt = 1'b0;
    end
    if (accept) begin
      hold_valid_nxt = 1'b1;
    end
  end

  assign in_stall  = hold_valid_r && !(step && done);
  assign pix_valid = step && has_pix;
  assign pix       = pix_c;
  assign busy      = hold_valid_r;

  assign pal_req.we    = step && (cmd_r == CMD_PAL);
  assign pal_req.waddr = pidx_r;
  assign pal_req.wdata = pcolor_r;
  assign pal_req.re    = step && has_pix && pix_c.use_pal;
  assign pal_req.raddr = idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      bit_pos_r    <= BYTE_BITS;
      row_pos_r    <= '0;
      bip_r        <= '0;
      partial_r    <= '0;
      skip_r       <= '0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      if (step) begin
        bit_pos_r <= bit_pos_nxt;
        row_pos_r <= row_pos_nxt;
        bip_r     <= bip_nxt;
        partial_r <= partial_nxt;
        skip_r    <= skip_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= in_cmd;
      byte_r   <= in_data_byte;
      pidx_r   <= in_pal_index;
      pcolor_r <= in_pal_color;
    end
  end

endmodule

/* design/ppu_out.sv */
// Result register: holds one pixel and merges in the palette read data.
// Depends on ppu_pkg.
`timescale 1ns / 1ps

module ppu_out (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          pix_valid,
  input  ppu_pkg::pix_t pix,
  input  logic [31:0]   pal_rdata,
  output logic          out_ready,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_pixel_index,
  output logic [7:0]    out_red,
  output logic [7:0]    out_green,
  output logic [7:0]    out_blue,
  output logic [7:0]    out_alpha,
  output logic          out_row_end,
  output logic          out_run_last
);
  import ppu_pkg::*;

  logic        valid_r;
  pix_t        pix_r;
  logic [31:0] color;

  assign out_ready = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_ready) begin
      valid_r <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && pix_valid) begin
      pix_r <= pix;
    end
  end

  assign color           = pix_r.use_pal ? pal_rdata : pix_r.color;
  assign out_valid       = valid_r;
  assign out_pixel_index = pix_r.pixel_index;
  assign out_red         = color[7:0];
  assign out_green       = color[15:8];
  assign out_blue        = color[23:16];
  assign out_alpha       = color[31:24];
  assign out_row_end     = pix_r.row_end;
  assign out_run_last    = pix_r.run_last;

endmodule

/* design/packed_pixel_unpacker_unit.sv */
// Packed pixel unpacker, top level: configuration registers and the word-to-pixel path.
// Depends on ppu_pkg, ppu_unpack, ppu_palette and ppu_out.
`timescale 1ns / 1ps

// Turns a stream of packed image bytes into RGBA pixels, at most one pixel per clock at
// the output while out_stall is low. An accepted word sits in a holding register; each
// cycle the unpacker takes one pixel from it unless the result register stalls, so a
// data byte stays in the holding register until all the pixels it yields have left
// (up to 8 at 1 bpp, 4 at 2 bpp, 2 at 4 bpp, otherwise 1; fewer when the row ends
// inside the byte). Palette writes, pad bytes and partial multi-byte pixels yield no
// pixel and never wait on the result register. The palette is a 256-entry memory
// with a registered read, which lines up with the result register: a pixel appears in
// the cycle after it leaves the holding register. The next word is
// accepted in the cycle its predecessor finishes. Configuration writes are always
// ready and must only be issued while the block is idle.

module packed_pixel_unpacker_unit #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_cmd,
  input  logic [7:0]                    in_data_byte,
  input  logic [7:0]                    in_pal_index,
  input  logic [31:0]                   in_pal_color,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_pixel_index,
  output logic [7:0]                    out_red,
  output logic [7:0]                    out_green,
  output logic [7:0]                    out_blue,
  output logic [7:0]                    out_alpha,
  output logic                          out_row_end,
  output logic                          out_run_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ppu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import ppu_pkg::*;

  logic [2:0]  depth_mode_r;
  logic [12:0] row_width_r;
  logic [7:0]  pad_bytes_r;

  logic        pix_valid, out_ready, busy;
  pix_t        pix;
  pal_req_t    pal_req;
  logic [31:0] pal_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_mode_r <= DEPTH_8;
      row_width_r  <= 13'd1;
      pad_bytes_r  <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEPTH: depth_mode_r <= cfg_data[2:0];
        CFG_WIDTH: row_width_r  <= cfg_data[12:0];
        CFG_PAD:   pad_bytes_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  ppu_unpack #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_unpack (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_cmd      (in_cmd),
    .in_data_byte(in_data_byte),
    .in_pal_index(in_pal_index),
    .in_pal_color(in_pal_color),
    .depth_mode  (depth_mode_r),
    .row_width   (row_width_r),
    .pad_bytes   (pad_bytes_r),
    .out_ready   (out_ready),
    .pix_valid   (pix_valid),
    .pix         (pix),
    .pal_req     (pal_req),
    .busy        (busy)
  );

  ppu_palette u_palette (
    .clk  (clk),
    .req  (pal_req),
    .rdata(pal_rdata)
  );

  ppu_out u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .pix_valid      (pix_valid),
    .pix            (pix),
    .pal_rdata      (pal_rdata),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_index(out_pixel_index),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_alpha      (out_alpha),
    .out_row_end    (out_row_end),
    .out_run_last   (out_run_last)
  );

  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> busy)
    else $error("input stalled with no word held");

  a_pal_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(pal_req.we && pal_req.re))
    else $error("palette read and write in the same cycle");

  a_no_pix_into_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !pix_valid)
    else $error("pixel issued while result register is stalled");

  a_pix_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    pix_valid |=> out_valid)
    else $error("issued pixel did not reach the result register");

endmodule
